FILE: src/cls_pkg.sv
package cls_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int OUT_BITS      = 48;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [1:0] STATUS_SOLVED   = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  localparam logic       REG_SYSTEM_SIZE = 1'b0;
  localparam logic [1:0] SIZE_TWO        = 2'd2;
  localparam logic [1:0] SIZE_RESET      = 2'd3;

endpackage

FILE: src/cls_det_unit.sv
module cls_det_unit #(
  parameter int CB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic signed [CB-1:0]  r1_i [4],
  input  logic signed [CB-1:0]  r2_i [4],
  input  logic signed [CB-1:0]  r3_i [4],
  output logic                  vld_o,
  output logic [3*CB+1:0]       dmag_o,
  output logic [3*CB+1:0]       nmag_o [3],
  output logic                  neg_o [3],
  output logic                  sing_o
);
  import cls_pkg::*;

  localparam int PW  = 2*CB;
  localparam int MNW = 2*CB+1;
  localparam int TW  = 3*CB+1;
  localparam int SW  = 3*CB+3;
  localparam int DW  = 3*CB+2;

  // column pairs of rows two and three: ab ac ad bc bd cd
  localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [6] = '{1, 2, 3, 2, 3, 3};
  // terms: det, nx, ny, nz, three each (row one column, minor, negate)
  localparam int TCOL [12] = '{0, 1, 2,  3, 1, 2,  0, 3, 2,  0, 1, 3};
  localparam int TMIN [12] = '{3, 1, 0,  3, 5, 4,  5, 1, 2,  4, 2, 0};
  localparam int TNEG [12] = '{0, 1, 0,  0, 0, 1,  1, 1, 0,  0, 1, 0};

  logic signed [PW-1:0]  pp_r [6];
  logic signed [PW-1:0]  pn_r [6];
  logic signed [MNW-1:0] mn_r [6];
  logic signed [TW-1:0]  tm_r [12];
  logic signed [DW-1:0]  sum_r [4];
  logic signed [DW-1:0]  sum_nxt [4];
  logic signed [CB-1:0]  r1a_r [4];
  logic signed [CB-1:0]  r1b_r [4];
  logic [4:0]            vld_r;
  logic [DW-1:0]         mag_nxt [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        pp_r[k] <= r2_i[PA[k]] * r3_i[PB[k]];
        pn_r[k] <= r2_i[PB[k]] * r3_i[PA[k]];
        mn_r[k] <= MNW'(pp_r[k]) - MNW'(pn_r[k]);
      end
      for (int c = 0; c < 4; c++) begin
        r1a_r[c] <= r1_i[c];
        r1b_r[c] <= r1a_r[c];
      end
      for (int t = 0; t < 12; t++) begin
        tm_r[t] <= TW'(r1b_r[TCOL[t]]) * TW'(mn_r[TMIN[t]]);
      end
      for (int o = 0; o < 4; o++) begin
        sum_r[o] <= sum_nxt[o];
      end
      dmag_o <= mag_nxt[0];
      sing_o <= (sum_r[0] == '0);
      for (int l = 0; l < 3; l++) begin
        nmag_o[l] <= mag_nxt[l+1];
        neg_o[l]  <= sum_r[l+1][DW-1] ^ sum_r[0][DW-1];
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int o = 0; o < 4; o++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        if (TNEG[3*o+j] != 0) begin
          acc = acc - SW'(tm_r[3*o+j]);
        end else begin
          acc = acc + SW'(tm_r[3*o+j]);
        end
      end
      sum_nxt[o] = DW'(acc);
      mag_nxt[o] = sum_r[o][DW-1] ? DW'(-sum_r[o]) : DW'(sum_r[o]);
    end
  end

  assign vld_o = vld_r[4];

endmodule

FILE: src/cls_div_cell.sv
module cls_div_cell #(
  parameter int MW = 50,
  parameter int QB = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] r_i,
  input  logic [QB-1:0] lo_i,
  input  logic [MW-1:0] d_i,
  input  logic [QB-1:0] q_i,
  input  logic          ovf_i,
  input  logic          neg_i,
  output logic [MW-1:0] r_o,
  output logic [QB-1:0] lo_o,
  output logic [MW-1:0] d_o,
  output logic [QB-1:0] q_o,
  output logic          ovf_o,
  output logic          neg_o
);
  import cls_pkg::*;

  logic [MW:0]   rr;
  logic [MW:0]   diff;
  logic          ge;
  logic [MW-1:0] r_nxt;

  assign rr    = {r_i, lo_i[QB-1]};
  assign diff  = rr - {1'b0, d_i};
  assign ge    = (rr >= {1'b0, d_i});
  assign r_nxt = ge ? diff[MW-1:0] : rr[MW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      r_o   <= r_nxt;
      lo_o  <= {lo_i[QB-2:0], 1'b0};
      d_o   <= d_i;
      q_o   <= {q_i[QB-2:0], ge};
      ovf_o <= ovf_i;
      neg_o <= neg_i;
    end
  end

endmodule

FILE: src/cls_divider.sv
module cls_divider #(
  parameter int MW = 50,
  parameter int QB = 48,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic          sing_i,
  input  logic [MW-1:0] d_i,
  input  logic [MW-1:0] n_i [3],
  input  logic          neg_i [3],
  output logic          vld_o,
  output logic          sing_o,
  output logic [QB-1:0] q_o [3],
  output logic          ovf_o [3],
  output logic          neg_o [3]
);
  import cls_pkg::*;

  localparam int EW = QB + MW;

  logic [QB-1:0] vld_r;
  logic [QB-1:0] sing_r;
  logic [MW-1:0] r_s   [3][QB+1];
  logic [QB-1:0] lo_s  [3][QB+1];
  logic [MW-1:0] d_s   [3][QB+1];
  logic [QB-1:0] q_s   [3][QB+1];
  logic          ovf_s [3][QB+1];
  logic          neg_s [3][QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[QB-2:0], sing_i};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [EW-1:0] ext;
    assign ext          = EW'(n_i[l]) << FB;
    assign r_s[l][0]    = ext[EW-1:QB];
    assign lo_s[l][0]   = ext[QB-1:0];
    assign d_s[l][0]    = d_i;
    assign q_s[l][0]    = '0;
    assign ovf_s[l][0]  = (ext[EW-1:QB] >= d_i);
    assign neg_s[l][0]  = neg_i[l];

    for (genvar g = 0; g < QB; g++) begin : g_cell
      cls_div_cell #(.MW(MW), .QB(QB)) u_cell (
        .clk   (clk),
        .en    (en),
        .r_i   (r_s[l][g]),
        .lo_i  (lo_s[l][g]),
        .d_i   (d_s[l][g]),
        .q_i   (q_s[l][g]),
        .ovf_i (ovf_s[l][g]),
        .neg_i (neg_s[l][g]),
        .r_o   (r_s[l][g+1]),
        .lo_o  (lo_s[l][g+1]),
        .d_o   (d_s[l][g+1]),
        .q_o   (q_s[l][g+1]),
        .ovf_o (ovf_s[l][g+1]),
        .neg_o (neg_s[l][g+1])
      );
    end

    assign q_o[l]   = q_s[l][QB];
    assign ovf_o[l] = ovf_s[l][QB];
    assign neg_o[l] = neg_s[l][QB];
  end

  assign vld_o  = vld_r[QB-1];
  assign sing_o = sing_r[QB-1];

endmodule

FILE: src/cramer_linear_solver.sv
// Cramer's rule solver for one 2x2 or 3x3 integer linear system per transfer.
// Input channel: twelve signed coefficients (three rows of x, y, z, rhs),
// moved on in_valid high and in_stall low. Result channel: sol_x, sol_y,
// sol_z as signed Q32.16 and a status (solved, singular, saturated), moved
// on out_valid high and out_stall low.
// system_size at APB byte address 0 selects 2x2 (value 2) or 3x3. The user
// must have it written only while the block is empty; the block does not check.
// From an input transfer to out_valid a system passes five stages of minors,
// products and sums, a row of 48 divider cells (one quotient bit per cell,
// three lanes side by side) and the output register.
// Throughput is one system per cycle; a new system enters every cycle that
// in_stall is low.
// When the receiver stalls, the output register holds and one more result
// is caught in a skid register; in_stall then rises and the whole pipeline
// freezes until the skid register has drained.
// Reset clears all valid flags and sets system_size to 3.
module cramer_linear_solver #(
  parameter int COEF_BITS = cls_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = cls_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r1_x,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r1_y,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r1_z,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r1_rhs,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r2_x,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r2_y,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r2_z,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r2_rhs,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r3_x,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r3_y,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r3_z,
  input  logic signed [cls_pkg::FIELD_W-1:0]    in_r3_rhs,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cls_pkg::OUT_BITS-1:0]   out_sol_x,
  output logic signed [cls_pkg::OUT_BITS-1:0]   out_sol_y,
  output logic signed [cls_pkg::OUT_BITS-1:0]   out_sol_z,
  output logic [1:0]                            out_status,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [cls_pkg::APB_AW-1:0]            cfg_paddr,
  input  logic [cls_pkg::APB_DW-1:0]            cfg_pwdata,
  output logic [cls_pkg::APB_DW-1:0]            cfg_prdata,
  output logic                                  cfg_pready
);
  import cls_pkg::*;

  localparam int CB = COEF_BITS;
  localparam int MW = 3*CB + 2;
  localparam int QB = OUT_BITS;

  logic [1:0]            size_r;
  logic                  two;
  logic                  en;
  logic signed [CB-1:0]  r1_v [4];
  logic signed [CB-1:0]  r2_v [4];
  logic signed [CB-1:0]  r3_v [4];
  logic                  dv_vld;
  logic [MW-1:0]         dv_dmag;
  logic [MW-1:0]         dv_nmag [3];
  logic                  dv_neg [3];
  logic                  dv_sing;
  logic                  q_vld;
  logic                  q_sing;
  logic [QB-1:0]         q_mag [3];
  logic                  q_ovf [3];
  logic                  q_neg [3];
  logic [QB-1:0]         res [3];
  logic [1:0]            res_status;
  logic                  out_vld_r;
  logic [QB-1:0]         out_sol_r [3];
  logic [1:0]            out_status_r;
  logic                  skid_vld_r;
  logic [QB-1:0]         skid_sol_r [3];
  logic [1:0]            skid_status_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SYSTEM_SIZE) ? APB_DW'(size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_SYSTEM_SIZE) begin
      size_r <= cfg_pwdata[1:0];
    end
  end

  assign two = (size_r == SIZE_TWO);

  // a 2x2 system is solved as a 3x3 one with third row (0, 0, 1 | 0) and z zeroed in rows one and two
  always_comb begin
    r1_v[0] = in_r1_x[CB-1:0];
    r1_v[1] = in_r1_y[CB-1:0];
    r1_v[2] = two ? '0 : in_r1_z[CB-1:0];
    r1_v[3] = in_r1_rhs[CB-1:0];
    r2_v[0] = in_r2_x[CB-1:0];
    r2_v[1] = in_r2_y[CB-1:0];
    r2_v[2] = two ? '0 : in_r2_z[CB-1:0];
    r2_v[3] = in_r2_rhs[CB-1:0];
    r3_v[0] = two ? '0 : in_r3_x[CB-1:0];
    r3_v[1] = two ? '0 : in_r3_y[CB-1:0];
    r3_v[2] = two ? CB'(1) : in_r3_z[CB-1:0];
    r3_v[3] = two ? '0 : in_r3_rhs[CB-1:0];
  end

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  cls_det_unit #(.CB(CB)) u_det (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .r1_i   (r1_v),
    .r2_i   (r2_v),
    .r3_i   (r3_v),
    .vld_o  (dv_vld),
    .dmag_o (dv_dmag),
    .nmag_o (dv_nmag),
    .neg_o  (dv_neg),
    .sing_o (dv_sing)
  );

  cls_divider #(.MW(MW), .QB(QB), .FB(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (dv_vld),
    .sing_i (dv_sing),
    .d_i    (dv_dmag),
    .n_i    (dv_nmag),
    .neg_i  (dv_neg),
    .vld_o  (q_vld),
    .sing_o (q_sing),
    .q_o    (q_mag),
    .ovf_o  (q_ovf),
    .neg_o  (q_neg)
  );

  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] val;
    logic          sat;
    logic          any_sat;
    any_sat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      lim = q_neg[l] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
      sat = q_ovf[l] || (q_mag[l] > lim);
      val = sat ? lim : q_mag[l];
      any_sat = any_sat | sat;
      res[l] = q_sing ? '0 : (q_neg[l] ? QB'(-val) : val);
    end
    if (q_sing) begin
      res_status = STATUS_SINGULAR;
    end else if (any_sat) begin
      res_status = STATUS_SAT;
    end else begin
      res_status = STATUS_SOLVED;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!skid_vld_r) begin
      if (!out_vld_r || !out_stall) begin
        out_vld_r <= q_vld;
      end else if (q_vld) begin
        skid_vld_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      if (!out_vld_r || !out_stall) begin
        out_sol_r    <= res;
        out_status_r <= res_status;
      end else begin
        skid_sol_r    <= res;
        skid_status_r <= res_status;
      end
    end else if (!out_stall) begin
      out_sol_r    <= skid_sol_r;
      out_status_r <= skid_status_r;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_sol_x  = out_sol_r[0];
  assign out_sol_y  = out_sol_r[1];
  assign out_sol_z  = out_sol_r[2];
  assign out_status = out_status_r;

endmodule

FILE: verif/tb_cramer_linear_solver.sv
`timescale 1ns / 1ps

module tb_cramer_linear_solver;
  import cls_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LATENCY = 60;
  localparam logic [APB_AW-1:0] ADDR_SIZE = APB_AW'(4 * REG_SYSTEM_SIZE);

  typedef logic signed [FIELD_W-1:0] coef_t;
  typedef logic signed [OUT_BITS-1:0] fix_t;

  typedef struct {
    coef_t c [12];
    int    gap;
  } system_t;

  typedef struct {
    fix_t       x;
    fix_t       y;
    fix_t       z;
    logic [1:0] st;
  } solution_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  coef_t in_c [12];
  logic out_valid, out_stall;
  fix_t out_sol_x, out_sol_y, out_sol_z;
  logic [1:0] out_status;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  system_t   pending_systems [$];
  solution_t expected_solutions [$];
  logic [1:0] size_reg;
  int errors, solved_cnt, singular_cnt, sat_cnt, two_cnt, cycles;
  bit hold_send;

  cramer_linear_solver uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_r1_x(in_c[0]), .in_r1_y(in_c[1]), .in_r1_z(in_c[2]), .in_r1_rhs(in_c[3]),
    .in_r2_x(in_c[4]), .in_r2_y(in_c[5]), .in_r2_z(in_c[6]), .in_r2_rhs(in_c[7]),
    .in_r3_x(in_c[8]), .in_r3_y(in_c[9]), .in_r3_z(in_c[10]), .in_r3_rhs(in_c[11]),
    .out_valid(out_valid), .out_stall(out_stall), .out_sol_x(out_sol_x),
    .out_sol_y(out_sol_y), .out_sol_z(out_sol_z), .out_status(out_status),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint minor2(longint a, longint b, longint c, longint d);
    return a * d - b * c;
  endfunction

  function automatic longint minor3(longint m [9]);
    return m[0] * minor2(m[4], m[5], m[7], m[8]) - m[1] * minor2(m[3], m[5], m[6], m[8])
         + m[2] * minor2(m[3], m[4], m[6], m[7]);
  endfunction

  // truncating fixed-point quotient with clamp to the 48-bit range
  function automatic fix_t quotient(longint num, longint den, inout bit sat);
    logic [127:0] n, d, q, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << 16) / d;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? fix_t'(-q) : fix_t'(q);
  endfunction

  function automatic solution_t solve_system(system_t s);
    solution_t r;
    longint v [12];
    longint m [9];
    longint det, nx, ny, nz;
    bit sat;
    sat = 1'b0;
    nz = 0;
    for (int i = 0; i < 12; i++) v[i] = s.c[i];
    if (size_reg == SIZE_TWO) begin
      det = minor2(v[0], v[1], v[4], v[5]);
      nx = minor2(v[3], v[1], v[7], v[5]);
      ny = minor2(v[0], v[3], v[4], v[7]);
    end else begin
      m = '{v[0], v[1], v[2], v[4], v[5], v[6], v[8], v[9], v[10]};
      det = minor3(m);
      m = '{v[3], v[1], v[2], v[7], v[5], v[6], v[11], v[9], v[10]};
      nx = minor3(m);
      m = '{v[0], v[3], v[2], v[4], v[7], v[6], v[8], v[11], v[10]};
      ny = minor3(m);
      m = '{v[0], v[1], v[3], v[4], v[5], v[7], v[8], v[9], v[11]};
      nz = minor3(m);
    end
    if (det == 0) begin
      r = '{x: '0, y: '0, z: '0, st: STATUS_SINGULAR};
    end else begin
      r.x = quotient(nx, det, sat);
      r.y = quotient(ny, det, sat);
      r.z = (size_reg == SIZE_TWO) ? fix_t'(0) : quotient(nz, det, sat);
      r.st = sat ? STATUS_SAT : STATUS_SOLVED;
    end
    return r;
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3, 4, 5: return coef_t'($urandom_range(0, 16) - 8);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // driver
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected_solutions.push_back(solve_system(pending_systems.pop_front()));
      if (hold_send || pending_systems.size() == 0) begin
        in_valid <= 1'b0;
        if (in_valid && pending_systems.size() > 0) gap_left <= pending_systems[0].gap;
      end else if (!in_valid && gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (in_valid && pending_systems[0].gap > 0) begin
        in_valid <= 1'b0;
        gap_left <= pending_systems[0].gap - 1;
      end else begin
        in_valid <= 1'b1;
        for (int i = 0; i < 12; i++) in_c[i] <= pending_systems[0].c[i];
      end
    end
  end

  // monitor
  int stall_left;
  always @(posedge clk) begin
    solution_t e;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_solutions.size() == 0) begin
          $display("%0t: unexpected result x=%0d", $time, out_sol_x);
          errors++;
        end else begin
          e = expected_solutions.pop_front();
          if (out_sol_x !== e.x || out_sol_y !== e.y || out_sol_z !== e.z
              || out_status !== e.st) begin
            $display("%0t: mismatch expected %0d %0d %0d st%0d actual %0d %0d %0d st%0d",
                     $time, e.x, e.y, e.z, e.st, out_sol_x, out_sol_y, out_sol_z, out_status);
            errors++;
          end
          case (e.st)
            STATUS_SINGULAR: singular_cnt++;
            STATUS_SAT: sat_cnt++;
            default: solved_cnt++;
          endcase
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0 && $urandom_range(0, 1)) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_system(coef_t c [12]);
    system_t s;
    s.c = c;
    s.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    pending_systems.push_back(s);
  endtask

  task automatic drain();
    wait (pending_systems.size() == 0);
    @(posedge clk);
    while (expected_solutions.size() > 0 || in_valid) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= ADDR_SIZE; cfg_pwdata <= APB_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    size_reg = v;
  endtask

  task automatic random_phase(int n);
    coef_t c [12];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 12; i++) c[i] = rand_coef();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 4; i++) c[4+i] = c[i];
      end
      add_system(c);
      if (size_reg == SIZE_TWO) two_cnt++;
    end
  endtask

  initial begin
    coef_t c [12];
    errors = 0; solved_cnt = 0; singular_cnt = 0; sat_cnt = 0; two_cnt = 0; cycles = 0;
    hold_send = 0; stall_left = 0;
    in_valid = 0; out_stall = 0;
    for (int i = 0; i < 12; i++) in_c[i] = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    size_reg = SIZE_RESET;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    c = '{1, 0, 0, 5, 0, 1, 0, -7, 0, 0, 1, 3};            add_system(c);
    c = '{2, 1, -1, 8, -3, -1, 2, -11, -2, 1, 2, -3};      add_system(c);
    c = '{1, 2, 3, 4, 2, 4, 6, 8, 1, 1, 1, 1};             add_system(c);
    c = '{3, 0, 0, 1, 0, 3, 0, -1, 0, 0, 3, 2};            add_system(c);
    c = '{1, 0, 0, 16'sh7fff, 0, 1, 0, 16'sh8000, 0, 0, 1, 0}; add_system(c);
    c = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
    add_system(c);
    c = '{1, 1, 1, 16'sh7fff, 1, 1, 2, 16'sh8000, 1, 2, 1, 16'sh7fff}; add_system(c);
    c = '{-1, 0, 0, -1, 0, -1, 0, 1, 0, 0, -1, -1};        add_system(c);
    random_phase(150);
    // sender holds off mid-batch until every outstanding result is back
    wait (pending_systems.size() <= 75);
    hold_send = 1;
    @(posedge clk);
    while (expected_solutions.size() > 0 || in_valid) @(posedge clk);
    hold_send = 0;
    drain();
    write_size(SIZE_TWO);
    c = '{2, 3, 99, 8, 1, -1, -5, -1, 7, 7, 7, 7};         add_system(c);
    c = '{1, 2, 0, 3, 2, 4, 0, 6, 0, 0, 0, 0};             add_system(c);
    c = '{1, 16'sh7fff, 0, 16'sh7fff, 1, 16'sh7ffe, 0, 16'sh8000, 0, 0, 0, 0};
    add_system(c);
    random_phase(300);
    drain();
    write_size(2'd0);
    random_phase(200);
    drain();
    write_size(2'd1);
    random_phase(150);
    drain();
    write_size(SIZE_RESET);
    random_phase(250);
    drain();
    $display("Covered %0d solved, %0d singular, %0d saturated systems; %0d in 2x2 form.",
             solved_cnt, singular_cnt, sat_cnt, two_cnt);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
